// ===== rtl/lgs_pkg.sv =====
package lgs_pkg;

   localparam int COLUMNS = 64;
   localparam int ROWS = 64;
   localparam int ROW_W = $clog2(ROWS);
   localparam int CNT_W = $clog2(ROWS + 2);

   typedef enum logic [1:0] {
      MODE_WRITE   = 2'd0,
      MODE_ADVANCE = 2'd1,
      MODE_READ    = 2'd2
   } mode_type;

   typedef struct packed {
      logic               wr_en;
      logic [ROW_W-1:0]   wr_addr;
      logic [COLUMNS-1:0] wr_cells;
      logic               rd_en;
      logic [ROW_W-1:0]   rd_addr;
   } ram_req_type;

endpackage

// ===== rtl/lgs_row_store.sv =====
module lgs_row_store
   import lgs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  ram_req_type        ram_req,
   output logic [COLUMNS-1:0] rd_cells
);

   logic [COLUMNS-1:0] mem [ROWS];
   logic [ROWS-1:0]    row_valid_ff;
   logic [ROWS-1:0]    row_valid_in;
   logic [COLUMNS-1:0] rd_data_ff;
   logic               rd_valid_ff;

   always_comb begin
      row_valid_in = row_valid_ff;
      if (ram_req.wr_en) begin
         row_valid_in[ram_req.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else begin
         row_valid_ff <= row_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_cells;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_req.rd_en) begin
         rd_data_ff  <= mem[ram_req.rd_addr];
         rd_valid_ff <= row_valid_ff[ram_req.rd_addr];
      end
   end

   // rows never written since reset read as dead
   assign rd_cells = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ===== rtl/lgs_next_row.sv =====
module lgs_next_row
   import lgs_pkg::*;
(
   input  logic [COLUMNS-1:0] above,
   input  logic [COLUMNS-1:0] here,
   input  logic [COLUMNS-1:0] below,
   output logic [COLUMNS-1:0] next_cells
);

   logic [COLUMNS+1:0] above_pad;
   logic [COLUMNS+1:0] here_pad;
   logic [COLUMNS+1:0] below_pad;
   logic [3:0]         count [COLUMNS];

   // dead border on both sides
   assign above_pad = {1'b0, above, 1'b0};
   assign here_pad  = {1'b0, here, 1'b0};
   assign below_pad = {1'b0, below, 1'b0};

   always_comb begin
      for (int c = 0; c < COLUMNS; c++) begin
         count[c] = 4'(above_pad[c]) + 4'(above_pad[c+1]) + 4'(above_pad[c+2])
                  + 4'(here_pad[c]) + 4'(here_pad[c+2])
                  + 4'(below_pad[c]) + 4'(below_pad[c+1]) + 4'(below_pad[c+2]);
         next_cells[c] = (count[c] == 4'd3) || (here[c] && (count[c] == 4'd2));
      end
   end

endmodule

// ===== rtl/life_generation_step_core.sv =====
// Life B3/S23 engine on a 64 x 64 grid held in a single-port-read row memory; cells
// outside the grid are dead. Every item gives one result on rsp_: write and unused
// mode 3 answer in the cycle after acceptance, a read goes through ST_READ and the
// result register, and an advance through the row sweep in ST_SWEEP: one memory read and one
// rewrite per cycle, all columns of a row updated in parallel. One item is in
// work at a time; a new item is taken once the previous result has been handed
// over or is being taken. The grid is dead after reset without any clearing pass.
module life_generation_step_core
   import lgs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [5:0]  req_row_index,
   input  logic [63:0] req_row_cells,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_read_cells,
   output logic [15:0] rsp_generation
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_READ  = 3'b010,
      ST_SWEEP = 3'b100
   } state_type;

   localparam logic [CNT_W-1:0] CNT_ROWS = CNT_W'(ROWS);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ROWS + 1);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   sweep_cnt_ff, sweep_cnt_in;
   logic [COLUMNS-1:0] above_ff, above_in;
   logic [COLUMNS-1:0] here_ff, here_in;
   logic [15:0]        gen_ff, gen_in;
   logic               in_range_ff, in_range_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [63:0]        rsp_cells_ff, rsp_cells_in;
   logic [15:0]        rsp_gen_ff, rsp_gen_in;

   ram_req_type        ram_req;
   logic [COLUMNS-1:0] rd_cells;
   logic [COLUMNS-1:0] below;
   logic [COLUMNS-1:0] next_cells;
   logic               accept;
   logic               req_in_range;

   lgs_row_store u_store (
      .clock   (clock),
      .reset   (reset),
      .ram_req (ram_req),
      .rd_cells(rd_cells)
   );

   lgs_next_row u_rule (
      .above     (above_ff),
      .here      (here_ff),
      .below     (below),
      .next_cells(next_cells)
   );

   assign req_ready    = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept       = req_valid && req_ready;
   assign req_in_range = 32'(req_row_index) < ROWS;
   assign below        = (sweep_cnt_ff <= CNT_ROWS) ? rd_cells : '0;

   always_comb begin
      state_in     = state_ff;
      sweep_cnt_in = sweep_cnt_ff;
      above_in     = above_ff;
      here_in      = here_ff;
      gen_in       = gen_ff;
      in_range_in  = in_range_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_cells_in = rsp_cells_ff;
      rsp_gen_in   = rsp_gen_ff;

      ram_req.wr_en    = 1'b0;
      ram_req.wr_addr  = ROW_W'(req_row_index);
      ram_req.wr_cells = req_row_cells[COLUMNS-1:0];
      ram_req.rd_en    = 1'b0;
      ram_req.rd_addr  = ROW_W'(req_row_index);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_mode)
                  MODE_WRITE: begin
                     ram_req.wr_en = req_in_range;
                     rsp_valid_in  = 1'b1;
                     rsp_cells_in  = '0;
                     rsp_gen_in    = gen_ff;
                  end
                  MODE_ADVANCE: begin
                     sweep_cnt_in = '0;
                     above_in     = '0;
                     here_in      = '0;
                     state_in     = ST_SWEEP;
                  end
                  MODE_READ: begin
                     ram_req.rd_en = req_in_range;
                     in_range_in   = req_in_range;
                     state_in      = ST_READ;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_cells_in = '0;
                     rsp_gen_in   = gen_ff;
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_cells_in = in_range_ff ? 64'(rd_cells) : '0;
            rsp_gen_in   = gen_ff;
            state_in     = ST_IDLE;
         end
         ST_SWEEP: begin
            // read row k, rewrite row k-2 from rows k-3 .. k-1
            ram_req.rd_en   = sweep_cnt_ff < CNT_ROWS;
            ram_req.rd_addr = ROW_W'(sweep_cnt_ff);
            if (sweep_cnt_ff >= CNT_W'(2)) begin
               ram_req.wr_en    = 1'b1;
               ram_req.wr_addr  = ROW_W'(sweep_cnt_ff - CNT_W'(2));
               ram_req.wr_cells = next_cells;
            end
            if (sweep_cnt_ff != '0) begin
               above_in = here_ff;
               here_in  = below;
            end
            sweep_cnt_in = sweep_cnt_ff + CNT_W'(1);
            if (sweep_cnt_ff == CNT_LAST) begin
               gen_in       = gen_ff + 16'd1;
               rsp_valid_in = 1'b1;
               rsp_cells_in = '0;
               rsp_gen_in   = gen_ff + 16'd1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gen_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gen_ff       <= gen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sweep_cnt_ff <= sweep_cnt_in;
      above_ff     <= above_in;
      here_ff      <= here_in;
      in_range_ff  <= in_range_in;
      rsp_cells_ff <= rsp_cells_in;
      rsp_gen_ff   <= rsp_gen_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_cells = rsp_cells_ff;
   assign rsp_generation = rsp_gen_ff;

   a_advance_enters_sweep: assert property (@(posedge clock) disable iff (reset)
      (accept && req_mode == MODE_ADVANCE) |=> state_ff == ST_SWEEP)
      else $error("advance item did not start a sweep");

   a_sweep_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP && ram_req.wr_en && ram_req.rd_en)
         |-> ram_req.wr_addr != ram_req.rd_addr)
      else $error("sweep rewrote a row not yet read");

   a_sweep_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP && sweep_cnt_ff == CNT_LAST)
         |=> rsp_valid_ff && rsp_gen_ff == gen_ff && rsp_cells_ff == '0)
      else $error("advance result wrong at end of sweep");

   a_slot_free_on_accept: assert property (@(posedge clock) disable iff (reset)
      accept |-> (!rsp_valid_ff || rsp_ready))
      else $error("item taken while result slot held");

endmodule

// ===== tb/sv/life_generation_step_core_tb.sv =====
module life_generation_step_core_tb
   import lgs_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int PHASE_ITEMS = 425;
   localparam int DRAIN_CYCLES = 80;
   localparam int HOLD_CYCLES = 300;

   class life_scoreboard;
      logic [COLUMNS-1:0] grid [ROWS];
      logic [15:0]        gen_count;
      logic [63:0]        exp_cells_q [$];
      logic [15:0]        exp_gen_q [$];
      int accepted;
      int writes;
      int reads;
      int advances;
      int unused_items;
      int results_seen;
      int mismatches;

      function new();
         foreach (grid[r]) grid[r] = '0;
         gen_count = '0;
      endfunction

      function void advance_generation();
         logic [COLUMNS-1:0] next_grid [ROWS];
         int n;
         for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < COLUMNS; c++) begin
               n = 0;
               for (int dr = -1; dr <= 1; dr++) begin
                  for (int dc = -1; dc <= 1; dc++) begin
                     if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < ROWS &&
                         c + dc >= 0 && c + dc < COLUMNS)
                        n += grid[r + dr][c + dc];
                  end
               end
               next_grid[r][c] = grid[r][c] ? (n == 2 || n == 3) : (n == 3);
            end
         end
         grid = next_grid;
         gen_count++;
      endfunction

      function void note_item(logic [1:0] mode, logic [5:0] row, logic [63:0] cells);
         logic [63:0] read_val;
         read_val = '0;
         accepted++;
         unique case (mode)
            MODE_WRITE: begin
               writes++;
               if (row < ROWS) grid[row] = cells[COLUMNS-1:0];
            end
            MODE_ADVANCE: begin
               advances++;
               advance_generation();
            end
            MODE_READ: begin
               reads++;
               if (row < ROWS) read_val = 64'(grid[row]);
            end
            default: unused_items++;
         endcase
         exp_cells_q.push_back(read_val);
         exp_gen_q.push_back(gen_count);
      endfunction

      function void check_result(logic [63:0] cells, logic [15:0] gen);
         logic [63:0] want_cells;
         logic [15:0] want_gen;
         results_seen++;
         if (exp_cells_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: cells %h generation %0d", cells, gen);
            return;
         end
         want_cells = exp_cells_q.pop_front();
         want_gen = exp_gen_q.pop_front();
         if (cells !== want_cells || gen !== want_gen) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"mismatch on result %0d: expected cells %h generation %0d,",
                         " got cells %h generation %0d"},
                        results_seen, want_cells, want_gen, cells, gen);
         end
      endfunction

      function int pending();
         return exp_cells_q.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_mode;
   logic [5:0]  req_row_index;
   logic [63:0] req_row_cells;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [63:0] rsp_read_cells;
   logic [15:0] rsp_generation;

   life_scoreboard board = new();
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_request = 0;
   int hold_left = 0;

   life_generation_step_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_row_index  (req_row_index),
      .req_row_cells  (req_row_cells),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_cells (rsp_read_cells),
      .rsp_generation (rsp_generation)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // receiver side: random stalls, or a long hold when asked for
   always @(negedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, board.pending());
         $display("Regression FAIL");
         $finish;
      end else if (!reset && rsp_valid && rsp_ready) begin
         board.check_result(rsp_read_cells, rsp_generation);
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] sparse_row();
      unique case ($urandom_range(3))
         0: return rand64() & rand64() & rand64();
         1, 2: return rand64() & rand64();
         default: return rand64();
      endcase
   endfunction

   // called at a falling edge; returns at the falling edge after the item is taken
   task automatic send_item(input logic [1:0] mode, input logic [5:0] row,
                            input logic [63:0] cells);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_row_index <= row;
      req_row_cells <= cells;
      do @(posedge clock); while (!req_ready);
      board.note_item(mode, row, cells);
      @(negedge clock);
   endtask

   // seed a band of rows, let it evolve, then read the band and its borders
   task automatic evolve_band();
      int base;
      int height;
      int steps;
      base = $urandom_range(ROWS - 1);
      height = $urandom_range(1, 8);
      steps = $urandom_range(1, 4);
      for (int i = 0; i < height; i++)
         send_item(MODE_WRITE, 6'(base + i), sparse_row());
      for (int i = 0; i < steps; i++)
         send_item(MODE_ADVANCE, 6'($urandom), rand64());
      for (int i = -2; i < height + 2; i++)
         send_item(MODE_READ, 6'(base + i), rand64());
   endtask

   task automatic random_traffic();
      int pick;
      pick = $urandom_range(99);
      if (pick < 55) begin
         evolve_band();
      end else if (pick < 75) begin
         send_item(MODE_READ, 6'($urandom), rand64());
      end else begin
         case ($urandom_range(3))
            0: send_item(MODE_WRITE, 6'($urandom), rand64());
            1: send_item(MODE_ADVANCE, 6'($urandom), rand64());
            2: send_item(MODE_READ, 6'($urandom), rand64());
            default: send_item(MODE_UNUSED, 6'($urandom), rand64());
         endcase
      end
   endtask

   initial begin
      int idle_set [4];
      int stall_set [4];
      int phase_start;
      idle_set = '{0, 51, 0, 8};
      stall_set = '{0, 0, 51, 8};
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = MODE_WRITE;
      req_row_index = '0;
      req_row_cells = '0;
      rsp_ready = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty grid, full edge rows, edge blinkers, unused mode
      send_item(MODE_READ, 6'd0, '0);
      send_item(MODE_READ, 6'd63, '1);
      send_item(MODE_WRITE, 6'd0, '1);
      send_item(MODE_WRITE, 6'd63, '1);
      send_item(MODE_READ, 6'd0, '0);
      send_item(MODE_READ, 6'd63, '0);
      send_item(MODE_ADVANCE, 6'd0, '0);
      send_item(MODE_READ, 6'd0, '0);
      send_item(MODE_READ, 6'd1, '0);
      send_item(MODE_READ, 6'd63, '0);
      send_item(MODE_UNUSED, 6'd5, '1);
      send_item(MODE_WRITE, 6'd0, '0);
      send_item(MODE_WRITE, 6'd63, '0);
      send_item(MODE_WRITE, 6'd31, 64'h7);
      send_item(MODE_WRITE, 6'd10, 64'hE000_0000_0000_0000);
      send_item(MODE_ADVANCE, 6'd63, '1);
      send_item(MODE_READ, 6'd30, '0);
      send_item(MODE_READ, 6'd31, '0);
      send_item(MODE_READ, 6'd32, '0);
      send_item(MODE_READ, 6'd9, '0);
      send_item(MODE_READ, 6'd10, '0);
      send_item(MODE_READ, 6'd11, '0);
      send_item(MODE_ADVANCE, 6'd0, '0);
      send_item(MODE_READ, 6'd31, '0);
      send_item(MODE_READ, 6'd1, '0);

      for (int p = 0; p < 4; p++) begin
         send_idle_pct = idle_set[p];
         recv_stall_pct = stall_set[p];
         if (p == 0) hold_request = HOLD_CYCLES;
         phase_start = board.accepted;
         while (board.accepted - phase_start < PHASE_ITEMS)
            random_traffic();
      end
      req_valid <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d items: %0d writes, %0d reads, %0d advances, %0d unused-mode",
               board.accepted, board.writes, board.reads, board.advances, board.unused_items);
      $display("four idle/stall phases plus one long output hold, final generation %0d",
               board.gen_count);
      if (board.mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches", board.mismatches);
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== life_generation_step_core.f =====
rtl/lgs_pkg.sv
rtl/lgs_row_store.sv
rtl/lgs_next_row.sv
rtl/life_generation_step_core.sv
tb/sv/life_generation_step_core_tb.sv
